// ===== hw/rtl/yaml_escape_to_utf8_decoder_unit_macros.svh =====
// Assertion macros used by the escape decoder unit RTL.
`ifndef YAML_ESCAPE_TO_UTF8_DECODER_UNIT_MACROS_SVH
`define YAML_ESCAPE_TO_UTF8_DECODER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define YED_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("yed: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define YED_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("yed: next-cycle check failed");

`endif

// ===== hw/rtl/yed_pkg.sv =====
// Types, character codes and UTF-8 encoding for the escape decoder.
`default_nettype none

package yed_pkg;

    // Decoder modes; the fourth code is never entered and decodes as plain.
    typedef enum logic [1:0] {
        MODE_PLAIN = 2'd0,
        MODE_ESC   = 2'd1,
        MODE_HEX   = 2'd2
    } t_mode;

    // Escape state carried from one input word to the next.
    typedef struct packed {
        t_mode       mode;
        logic [31:0] accum;
        logic [3:0]  digits;
    } t_state;

    // Up to five output bytes caused by one input word, first byte at index 0.
    localparam int unsigned MaxBytes = 5;
    typedef struct packed {
        logic [MaxBytes-1:0][7:0] bytes;
        logic [2:0]               cnt;
    } t_bundle;

    // One to four UTF-8 bytes of a code point.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      cnt;
    } t_utf8;

    // Character codes.
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UF     = 8'h46;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LF     = 8'h66;
    localparam logic [7:0] CH_LB     = 8'h62;
    localparam logic [7:0] CH_LT     = 8'h74;
    localparam logic [7:0] CH_LN     = 8'h6E;
    localparam logic [7:0] CH_LV     = 8'h76;
    localparam logic [7:0] CH_LR     = 8'h72;
    localparam logic [7:0] CH_LE     = 8'h65;
    localparam logic [7:0] CH_UN     = 8'h4E;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_UL     = 8'h4C;
    localparam logic [7:0] CH_UP     = 8'h50;
    localparam logic [7:0] CH_LX     = 8'h78;
    localparam logic [7:0] CH_LU     = 8'h75;
    localparam logic [7:0] CH_UU     = 8'h55;

    // Control bytes produced by the single-letter escapes.
    localparam logic [7:0] BYTE_NUL = 8'h00;
    localparam logic [7:0] BYTE_BEL = 8'h07;
    localparam logic [7:0] BYTE_BS  = 8'h08;
    localparam logic [7:0] BYTE_TAB = 8'h09;
    localparam logic [7:0] BYTE_LF  = 8'h0A;
    localparam logic [7:0] BYTE_VT  = 8'h0B;
    localparam logic [7:0] BYTE_FF  = 8'h0C;
    localparam logic [7:0] BYTE_CR  = 8'h0D;
    localparam logic [7:0] BYTE_ESC = 8'h1B;

    // Code points of the named Unicode escapes.
    localparam logic [31:0] CP_NEL  = 32'h0000_0085;
    localparam logic [31:0] CP_NBSP = 32'h0000_00A0;
    localparam logic [31:0] CP_LS   = 32'h0000_2028;
    localparam logic [31:0] CP_PS   = 32'h0000_2029;

    // Encoding range limits.
    localparam logic [31:0] LIM_1B = 32'h0000_007F;
    localparam logic [31:0] LIM_2B = 32'h0000_07FF;
    localparam logic [31:0] LIM_3B = 32'h0000_FFFF;
    localparam logic [31:0] LIM_4B = 32'h001F_FFFF;

    // Hex digit count for each code point escape.
    localparam logic [3:0] DIGITS_X  = 4'd2;
    localparam logic [3:0] DIGITS_U4 = 4'd4;
    localparam logic [3:0] DIGITS_U8 = 4'd8;

    // Hex digit test: bit 4 flags a digit, bits 3:0 give its value.
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [7:0] v;
        begin
            v = 8'h00;
            if (b >= CH_ZERO && b <= CH_NINE) begin
                v = b - CH_ZERO;
                hex_digit = {1'b1, v[3:0]};
            end else if (b >= CH_UA && b <= CH_UF) begin
                v = b - CH_UA + 8'd10;
                hex_digit = {1'b1, v[3:0]};
            end else if (b >= CH_LA && b <= CH_LF) begin
                v = b - CH_LA + 8'd10;
                hex_digit = {1'b1, v[3:0]};
            end else begin
                hex_digit = 5'd0;
            end
        end
    endfunction

    // UTF-8 encoding; a value beyond the four-byte range gives no bytes.
    function automatic t_utf8 utf8_encode(input logic [31:0] cp);
        t_utf8 r;
        begin
            r.bytes = '0;
            r.cnt   = 3'd0;
            if (cp <= LIM_1B) begin
                r.bytes[0] = cp[7:0];
                r.cnt      = 3'd1;
            end else if (cp <= LIM_2B) begin
                r.bytes[0] = {3'b110, cp[10:6]};
                r.bytes[1] = {2'b10, cp[5:0]};
                r.cnt      = 3'd2;
            end else if (cp <= LIM_3B) begin
                r.bytes[0] = {4'b1110, cp[15:12]};
                r.bytes[1] = {2'b10, cp[11:6]};
                r.bytes[2] = {2'b10, cp[5:0]};
                r.cnt      = 3'd3;
            end else if (cp <= LIM_4B) begin
                r.bytes[0] = {5'b11110, cp[20:18]};
                r.bytes[1] = {2'b10, cp[17:12]};
                r.bytes[2] = {2'b10, cp[11:6]};
                r.bytes[3] = {2'b10, cp[5:0]};
                r.cnt      = 3'd4;
            end
            utf8_encode = r;
        end
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/yed_in_if.sv =====
// Input channel: one raw byte or a flush marker per word.
`default_nettype none

interface yed_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       flush;

    modport source (output valid, output in_byte, output flush, input ready);
    modport sink (input valid, input in_byte, input flush, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/yed_out_if.sv =====
// Output channel: one decoded byte per word, last marks the end of a group.
`default_nettype none

interface yed_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink (input valid, input out_byte, input last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/yed_decode.sv =====
// Escape state register and the decode of one input word into a byte group.
`default_nettype none

module yed_decode (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_take,
    input  wire logic [7:0]      i_byte,
    input  wire logic            i_flush,
    output yed_pkg::t_bundle     o_bundle
);
    import yed_pkg::*;

    t_state     r_st;
    t_state     n_st;
    logic [4:0] hex;
    logic       code_en;
    logic [31:0] code_cp;
    logic       extra_en;
    logic [7:0] extra_b;
    t_utf8      enc;
    logic [2:0] code_cnt;
    logic [31:0] acc_shift;
    logic [3:0] dig_dec;

    assign hex       = hex_digit(i_byte);
    assign acc_shift = {r_st.accum[27:0], hex[3:0]};
    assign dig_dec   = r_st.digits - 4'd1;

    // Next escape state and what this word emits: a code point, then one byte.
    always_comb begin
        n_st     = r_st;
        code_en  = 1'b0;
        code_cp  = r_st.accum;
        extra_en = 1'b0;
        extra_b  = i_byte;
        if (i_flush) begin
            n_st.mode   = MODE_PLAIN;
            n_st.accum  = 32'd0;
            n_st.digits = 4'd0;
        end else begin
            unique case (r_st.mode)
                MODE_ESC: begin
                    n_st.mode = MODE_PLAIN;
                    extra_en  = 1'b1;
                    unique case (i_byte)
                        CH_ZERO:  extra_b = BYTE_NUL;
                        CH_LA:    extra_b = BYTE_BEL;
                        CH_LB:    extra_b = BYTE_BS;
                        CH_LT:    extra_b = BYTE_TAB;
                        CH_LN:    extra_b = BYTE_LF;
                        CH_LV:    extra_b = BYTE_VT;
                        CH_LF:    extra_b = BYTE_FF;
                        CH_LR:    extra_b = BYTE_CR;
                        CH_LE:    extra_b = BYTE_ESC;
                        CH_UN: begin
                            extra_en = 1'b0;
                            code_en  = 1'b1;
                            code_cp  = CP_NEL;
                        end
                        CH_UNDER: begin
                            extra_en = 1'b0;
                            code_en  = 1'b1;
                            code_cp  = CP_NBSP;
                        end
                        CH_UL: begin
                            extra_en = 1'b0;
                            code_en  = 1'b1;
                            code_cp  = CP_LS;
                        end
                        CH_UP: begin
                            extra_en = 1'b0;
                            code_en  = 1'b1;
                            code_cp  = CP_PS;
                        end
                        CH_LX, CH_LU, CH_UU: begin
                            extra_en    = 1'b0;
                            n_st.mode   = MODE_HEX;
                            n_st.accum  = 32'd0;
                            n_st.digits = (i_byte == CH_LX) ? DIGITS_X :
                                          (i_byte == CH_LU) ? DIGITS_U4 : DIGITS_U8;
                        end
                        default: extra_b = i_byte;
                    endcase
                end
                MODE_HEX: begin
                    if (hex[4] && r_st.digits != 4'd0) begin
                        // Another digit; the last one closes the escape.
                        n_st.accum  = acc_shift;
                        n_st.digits = dig_dec;
                        if (dig_dec == 4'd0) begin
                            code_en    = 1'b1;
                            code_cp    = acc_shift;
                            n_st.mode  = MODE_PLAIN;
                            n_st.accum = 32'd0;
                        end
                    end else begin
                        // Digits ended early: emit the value, then treat the byte.
                        code_en     = 1'b1;
                        n_st.accum  = 32'd0;
                        n_st.digits = 4'd0;
                        n_st.mode   = MODE_PLAIN;
                        if (!hex[4] && i_byte == CH_BSLASH) begin
                            n_st.mode = MODE_ESC;
                        end else begin
                            extra_en = 1'b1;
                        end
                    end
                end
                default: begin
                    if (i_byte == CH_BSLASH) begin
                        n_st.mode = MODE_ESC;
                    end else begin
                        n_st.mode = MODE_PLAIN;
                        extra_en  = 1'b1;
                    end
                end
            endcase
        end
    end

    // Pack the code point bytes and the trailing byte into one group.
    assign enc      = utf8_encode(code_cp);
    assign code_cnt = code_en ? enc.cnt : 3'd0;

    always_comb begin
        o_bundle.cnt = code_cnt + {2'b00, extra_en};
        for (int i = 0; i < MaxBytes; i++) begin
            if (i < 4 && 3'(i) < code_cnt) begin
                o_bundle.bytes[i] = enc.bytes[i % 4];
            end else begin
                o_bundle.bytes[i] = extra_b;
            end
        end
    end

    // Escape state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.mode   <= MODE_PLAIN;
            r_st.accum  <= 32'd0;
            r_st.digits <= 4'd0;
        end else if (i_take) begin
            r_st <= n_st;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/yaml_escape_to_utf8_decoder_unit.sv =====
// An accepted word's group is registered in the group queue before its bytes are offered.
// One input word per cycle is taken while the queue is not full and each word yields
// at most one byte; a word yielding k bytes (up to five) holds the single-byte output
// port until its bytes are taken. Input waits while the two-entry group queue is full.
// Reset (synchronous, active low) clears the escape state and empties the group queue.
`default_nettype none

module yaml_escape_to_utf8_decoder_unit (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    yed_in_if.sink    i_in,
    yed_out_if.source o_out
);
    import yed_pkg::*;

    `include "yaml_escape_to_utf8_decoder_unit_macros.svh"

    t_bundle    dec_bundle;
    t_bundle    r_slot [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic [2:0] r_idx;
    t_bundle    cur;
    logic       take;
    logic       push;
    logic       pop;
    logic       is_last;

    // Decode stage; it advances the escape state on every accepted word.
    yed_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_byte   (i_in.in_byte),
        .i_flush  (i_in.flush),
        .o_bundle (dec_bundle)
    );

    // Handshakes; words that yield no bytes do not enter the queue.
    assign i_in.ready = (r_cnt != 2'd2);
    assign take       = i_in.valid && i_in.ready;
    assign push       = take && (dec_bundle.cnt != 3'd0);
    assign cur        = r_slot[r_rp];
    assign is_last    = (r_idx == 3'(cur.cnt - 3'd1));
    assign pop        = o_out.valid && o_out.ready && is_last;

    // Byte serializer over the head group.
    assign o_out.valid    = (r_cnt != 2'd0);
    assign o_out.out_byte = cur.bytes[r_idx];
    assign o_out.last     = is_last;

    // Group payload storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wp] <= dec_bundle;
        end
    end

    // Queue pointers, fill count and byte index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
            r_idx <= 3'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp  <= ~r_rp;
                r_idx <= 3'd0;
            end else if (o_out.valid && o_out.ready) begin
                r_idx <= r_idx + 3'd1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    // A queued group always holds one to five bytes and the index stays inside it.
    `YED_ASSERT_NOW(a_group_size, o_out.valid, cur.cnt != 3'd0 && cur.cnt <= 3'd5)
    `YED_ASSERT_NOW(a_idx_in_group, o_out.valid, r_idx < cur.cnt)
    // The queue never overfills.
    `YED_ASSERT_NOW(a_no_overfill, 1'b1, r_cnt != 2'd3)
    // A push without a pop grows the queue by one group.
    `YED_ASSERT_NEXT(a_push_grows, push && !pop, r_cnt == $past(r_cnt) + 2'd1)

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for the YAML escape to UTF-8 decoder unit.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import yed_pkg::*;

    // One decoded output word as the block should present it.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_decoded_word;

    // Escape letters drawn by the random part, plus a backslash and a quote.
    localparam logic [7:0] ESCAPE_LETTERS [18] = '{
        CH_ZERO, CH_LA, CH_LB, CH_LT, CH_LN, CH_LV, CH_LF, CH_LR, CH_LE,
        CH_UN, CH_UNDER, CH_UL, CH_UP, CH_LX, CH_LU, CH_UU, CH_BSLASH, 8'h22
    };

    // Decoder prediction and comparison against the bytes the block emits.
    class escape_scoreboard;
        t_mode         mode;
        logic [31:0]   accum;
        logic [3:0]    digits_left;
        logic [7:0]    group_q[$];
        t_decoded_word expected_q[$];
        int            errors;

        function new();
            clear_escape();
            errors = 0;
        endfunction

        function void clear_escape();
            mode        = MODE_PLAIN;
            accum       = '0;
            digits_left = '0;
        endfunction

        // Add one byte to the group caused by the current input word.
        function void queue_byte(logic [7:0] b);
            group_q = {group_q, b};
        endfunction

        // UTF-8 bytes of a collected code point; nothing above the four-byte range.
        function void emit_code(logic [31:0] cp);
            if (cp <= LIM_1B) begin
                queue_byte(cp[7:0]);
            end else if (cp <= LIM_2B) begin
                queue_byte({3'b110, cp[10:6]});
                queue_byte({2'b10, cp[5:0]});
            end else if (cp <= LIM_3B) begin
                queue_byte({4'b1110, cp[15:12]});
                queue_byte({2'b10, cp[11:6]});
                queue_byte({2'b10, cp[5:0]});
            end else if (cp <= LIM_4B) begin
                queue_byte({5'b11110, cp[20:18]});
                queue_byte({2'b10, cp[17:12]});
                queue_byte({2'b10, cp[11:6]});
                queue_byte({2'b10, cp[5:0]});
            end
        endfunction

        // A backslash opens an escape, anything else passes through.
        function void take_plain(logic [7:0] b);
            if (b == CH_BSLASH) begin
                mode = MODE_ESC;
            end else begin
                mode = MODE_PLAIN;
                queue_byte(b);
            end
        endfunction

        function void take_letter(logic [7:0] b);
            mode = MODE_PLAIN;
            case (b)
                CH_ZERO:  queue_byte(BYTE_NUL);
                CH_LA:    queue_byte(BYTE_BEL);
                CH_LB:    queue_byte(BYTE_BS);
                CH_LT:    queue_byte(BYTE_TAB);
                CH_LN:    queue_byte(BYTE_LF);
                CH_LV:    queue_byte(BYTE_VT);
                CH_LF:    queue_byte(BYTE_FF);
                CH_LR:    queue_byte(BYTE_CR);
                CH_LE:    queue_byte(BYTE_ESC);
                CH_UN:    emit_code(CP_NEL);
                CH_UNDER: emit_code(CP_NBSP);
                CH_UL:    emit_code(CP_LS);
                CH_UP:    emit_code(CP_PS);
                CH_LX, CH_LU, CH_UU: begin
                    mode        = MODE_HEX;
                    accum       = '0;
                    digits_left = (b == CH_LX) ? DIGITS_X : (b == CH_LU) ? DIGITS_U4 : DIGITS_U8;
                end
                default:  queue_byte(b);
            endcase
        endfunction

        // Work out the bytes caused by one accepted input word.
        function void note_input(logic [7:0] b, logic fl);
            logic          is_hex;
            logic [3:0]    nib;
            t_decoded_word w;
            is_hex = 1'b1;
            nib    = '0;
            group_q.delete();
            if (b >= CH_ZERO && b <= CH_NINE) begin
                nib = 4'(b - CH_ZERO);
            end else if (b >= CH_UA && b <= CH_UF) begin
                nib = 4'(b - CH_UA + 8'd10);
            end else if (b >= CH_LA && b <= CH_LF) begin
                nib = 4'(b - CH_LA + 8'd10);
            end else begin
                is_hex = 1'b0;
            end

            if (fl) begin
                clear_escape();
            end else if (mode == MODE_ESC) begin
                take_letter(b);
            end else if (mode == MODE_HEX) begin
                if (is_hex && digits_left != 0) begin
                    accum       = {accum[27:0], nib};
                    digits_left = digits_left - 4'd1;
                    if (digits_left == 0) begin
                        emit_code(accum);
                        mode  = MODE_PLAIN;
                        accum = '0;
                    end
                end else begin
                    // The digits end early: flush the value, then treat the byte normally.
                    emit_code(accum);
                    clear_escape();
                    if (is_hex) begin
                        queue_byte(b);
                    end else begin
                        take_plain(b);
                    end
                end
            end else begin
                take_plain(b);
            end

            foreach (group_q[i]) begin
                w.data     = group_q[i];
                w.last     = (i == group_q.size() - 1);
                expected_q = {expected_q, w};
            end
        endfunction

        task log_mismatch(string msg);
            $display("%0t ns: mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_result(logic [7:0] data, logic last);
            t_decoded_word want;
            if (expected_q.size() == 0) begin
                log_mismatch($sformatf("unexpected word data=%02h last=%0b", data, last));
            end else begin
                want = expected_q.pop_front();
                if (data !== want.data) begin
                    log_mismatch($sformatf("out_byte %02h, want %02h", data, want.data));
                end
                if (last !== want.last) begin
                    log_mismatch($sformatf("last %0b, want %0b (byte %02h)",
                                           last, want.last, want.data));
                end
            end
        endtask

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    yed_in_if  byte_in ();
    yed_out_if byte_out ();

    yaml_escape_to_utf8_decoder_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_in.sink),
        .o_out   (byte_out.source)
    );

    escape_scoreboard sb = new();

    int tx_idle_pct = 11;
    int rx_idle_pct = 64;
    int words_sent  = 0;
    bit hold_req    = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Offer one word, with random idle cycles ahead of it, until it is taken.
    task automatic send_word(input logic [7:0] b, input logic fl);
        while ($urandom_range(99) < tx_idle_pct) begin
            byte_in.valid <= 1'b0;
            @(posedge i_clk);
        end
        byte_in.valid   <= 1'b1;
        byte_in.in_byte <= b;
        byte_in.flush   <= fl;
        @(posedge i_clk);
        while (!byte_in.ready) @(posedge i_clk);
        sb.note_input(b, fl);
        words_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
    endtask

    // Random hex digit character; tame digits keep an eight-digit value in range.
    function automatic logic [7:0] hex_char(int pos, int full, bit tame);
        int v;
        v = $urandom_range(15);
        if (tame && full == 8 && pos < 2) v = 0;
        else if (tame && full == 8 && pos == 2) v = $urandom_range(1);
        if (v < 10) return 8'(CH_ZERO + v);
        return 8'((($urandom_range(1) != 0) ? CH_UA : CH_LA) + v - 10);
    endfunction

    // One random token: a plain byte, a flush, or a whole escape sequence.
    task automatic send_token();
        int         pick;
        int         full;
        int         nd;
        bit         tame;
        logic [7:0] letter;
        pick = $urandom_range(99);
        if (pick < 40) begin
            send_word(8'($urandom_range(255)), 1'b0);
        end else if (pick < 45) begin
            send_word(8'($urandom_range(255)), 1'b1);
        end else begin
            if ($urandom_range(5) == 0) letter = 8'($urandom_range(255));
            else letter = ESCAPE_LETTERS[$urandom_range(17)];
            send_word(CH_BSLASH, 1'b0);
            send_word(letter, 1'b0);
            full = (letter == CH_LX) ? 2 : (letter == CH_LU) ? 4 : (letter == CH_UU) ? 8 : 0;
            if (full != 0) begin
                tame = ($urandom_range(4) != 0);
                nd   = ($urandom_range(9) < 7) ? full : $urandom_range(full - 1);
                for (int k = 0; k < nd; k++) send_word(hex_char(k, full, tame), 1'b0);
                // A short escape ends on a random byte or is dropped by a flush.
                if (nd < full) begin
                    send_word(8'($urandom_range(255)), ($urandom_range(3) == 0));
                end
            end
        end
    endtask

    // Receiver: check each accepted word, then pick ready for the next cycle.
    initial begin
        int hold_left;
        hold_left = 0;
        byte_out.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && byte_out.valid && byte_out.ready) begin
                sb.check_result(byte_out.out_byte, byte_out.last);
            end
            if (hold_req) begin
                hold_left = 300;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                byte_out.ready <= 1'b0;
            end else begin
                byte_out.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Main sequence: reset, directed words, then three idling phases.
    initial begin
        byte_in.valid   <= 1'b0;
        byte_in.in_byte <= '0;
        byte_in.flush   <= 1'b0;
        i_rst_n         <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Byte extremes, a control escape, a three-byte named escape, an unknown letter.
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_text("\\e\\P\\\"");
        // Hex escape with no digits, then one cut short by a new escape.
        send_text("\\xg\\ua\\N");
        // A pending escape dropped by a flush.
        send_text("\\x");
        send_word(8'hA5, 1'b1);
        // A value beyond the four-byte range gives nothing, then the ending byte.
        send_text("\\U3FFFFFz");

        while (words_sent < 80) send_token();
        tx_idle_pct = 64;
        rx_idle_pct = 11;
        while (words_sent < 140) send_token();
        // No idling, but the receiver holds off while words keep coming.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req    = 1'b1;
        while (words_sent < 200) send_token();
        byte_in.valid <= 1'b0;

        for (int n = 0; n < 20000 && sb.pending() != 0; n++) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.pending() != 0) begin
            sb.log_mismatch($sformatf("%0d expected words never arrived", sb.pending()));
        end
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #3ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
